// ===== rtl/core/slcs_pkg.sv =====
// Shared types and constants for the shell line context scanner.
// Holds the input and result beat structs and the character codes.
// No dependencies.
`timescale 1ns / 1ps

package slcs_pkg;

  localparam int unsigned MAX_DEPTH_DEF  = 15;
  localparam int unsigned LINE_LIMIT_DEF = 1023;

  localparam int unsigned OUT_POS_W = 10;
  localparam logic [OUT_POS_W-1:0] WORD_SAT = 10'd1023;

  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       no_char;
    logic       cursor_here;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] word_start_pos;
    logic [OUT_POS_W-1:0] words_before;
    logic                 in_special;
    logic                 first_valid;
    logic [OUT_POS_W-1:0] first_start_pos;
    logic [OUT_POS_W-1:0] first_end_pos;
    logic                 depth_overflow;
  } out_beat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/core/shell_line_context_scanner.sv =====
// Shell line context scanner: one character beat per cycle, result on the cursor beat.
// The result beat is registered and is valid in the cycle after the cursor beat is accepted.
// Throughput: one input beat per cycle; only a result held by out_ready stalls input.
// Reset (rst, synchronous): clears scan state and the result valid flag.
// Depends on slcs_pkg and slcs_track.
`timescale 1ns / 1ps

module shell_line_context_scanner import slcs_pkg::*; #(
  parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      take;
  out_beat_t result;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  slcs_track #(
    .MAX_DEPTH  (MAX_DEPTH),
    .LINE_LIMIT (LINE_LIMIT)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .beat   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_data.cursor_here) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.cursor_here) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/core/slcs_track.sv =====
// Scan state of the shell line context scanner: nesting, words, positions.
// Updates once per accepted beat and forms the result of a cursor beat.
// Depends on slcs_pkg.
`timescale 1ns / 1ps

module slcs_track import slcs_pkg::*; #(
  parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_beat_t  beat,
  output out_beat_t result
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned POS_W   = $clog2(LINE_LIMIT + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(LINE_LIMIT);

  logic                 string_open, string_open_next;
  logic                 escape_pending, escape_pending_next;
  logic [DEPTH_W-1:0]   paren_depth, paren_depth_next;
  logic [DEPTH_W-1:0]   brace_depth, brace_depth_next;
  logic [DEPTH_W-1:0]   bracket_depth, bracket_depth_next;
  logic                 dollar_pending, dollar_pending_next;
  logic                 word_open, word_open_next;
  logic [POS_W-1:0]     current_word_start, current_word_start_next;
  logic [OUT_POS_W-1:0] word_total, word_total_next;
  logic [POS_W-1:0]     first_word_begin, first_word_begin_next;
  logic [POS_W-1:0]     first_word_finish, first_word_finish_next;
  logic                 first_word_seen, first_word_seen_next;
  logic [POS_W-1:0]     char_position, char_position_next;
  logic                 overflow_seen, overflow_seen_next;

  always_comb begin : step
    logic             so, ep, dp, wo, fs, ov, consumed, ctx;
    logic [DEPTH_W-1:0] pd, bd, kd;
    logic [POS_W-1:0] cws, fb, ff, pos;
    logic [OUT_POS_W-1:0] wt;
    logic [7:0]       c;

    so  = string_open;
    ep  = escape_pending;
    pd  = paren_depth;
    bd  = brace_depth;
    kd  = bracket_depth;
    dp  = dollar_pending;
    wo  = word_open;
    cws = current_word_start;
    wt  = word_total;
    fb  = first_word_begin;
    ff  = first_word_finish;
    fs  = first_word_seen;
    pos = char_position;
    ov  = overflow_seen;
    c   = beat.char_code;
    consumed = 1'b0;
    ctx = 1'b0;

    if (!beat.no_char) begin
      if (dp) begin
        dp = 1'b0;
        if (c == CH_LBRACE) begin
          consumed = 1'b1;
          if (bd >= DEPTH_MAX) ov = 1'b1;
          else bd = bd + 1'b1;
        end else if (c == CH_LPAREN && !so) begin
          consumed = 1'b1;
          if (pd >= DEPTH_MAX) ov = 1'b1;
          else pd = pd + 1'b1;
        end
      end

      if (!consumed) begin
        ctx = so || (pd != '0) || (bd != '0) || (kd != '0);
        if (!ctx) begin
          if (is_blank(c)) begin
            if (wo) begin
              if (!fs) begin
                fs = 1'b1;
                fb = cws;
                ff = pos;
              end
              if (wt < WORD_SAT) wt = wt + 1'b1;
              wo = 1'b0;
            end
          end else if (!wo) begin
            wo  = 1'b1;
            cws = pos;
          end
        end

        if (so) begin
          if (ep) ep = 1'b0;
          else if (c == CH_BACKSLASH) ep = 1'b1;
          else if (c == CH_DOLLAR) dp = 1'b1;
          else if (c == CH_QUOTE) so = 1'b0;
        end else if (bd != '0) begin
          if (c == CH_QUOTE) so = 1'b1;
          else if (c == CH_RBRACE) bd = bd - 1'b1;
          else if (c == CH_DOLLAR) dp = 1'b1;
          else if (c == CH_LPAREN) begin
            if (pd >= DEPTH_MAX) ov = 1'b1;
            else pd = pd + 1'b1;
          end else if (c == CH_RPAREN && pd != '0) pd = pd - 1'b1;
        end else if (pd != '0) begin
          if (c == CH_QUOTE) so = 1'b1;
          else if (c == CH_DOLLAR) dp = 1'b1;
          else if (c == CH_LPAREN) begin
            if (pd >= DEPTH_MAX) ov = 1'b1;
            else pd = pd + 1'b1;
          end else if (c == CH_RPAREN) pd = pd - 1'b1;
        end else begin
          if (c == CH_QUOTE) so = 1'b1;
          else if (c == CH_DOLLAR) dp = 1'b1;
          else if (c == CH_LBRACKET) begin
            if (kd >= DEPTH_MAX) ov = 1'b1;
            else kd = kd + 1'b1;
          end else if (c == CH_RBRACKET && kd != '0) kd = kd - 1'b1;
        end
      end

      if (pos < POS_MAX) pos = pos + 1'b1;
      else ov = 1'b1;
    end

    result.word_start_pos  = OUT_POS_W'(32'(wo ? cws : pos));
    result.words_before    = wt;
    result.in_special      = so || (pd != '0) || (bd != '0) || (kd != '0);
    result.first_valid     = fs;
    result.first_start_pos = fs ? OUT_POS_W'(32'(fb)) : '0;
    result.first_end_pos   = fs ? OUT_POS_W'(32'(ff)) : '0;
    result.depth_overflow  = ov;

    if (beat.cursor_here) begin
      so  = 1'b0;
      ep  = 1'b0;
      pd  = '0;
      bd  = '0;
      kd  = '0;
      dp  = 1'b0;
      wo  = 1'b0;
      cws = '0;
      wt  = '0;
      fb  = '0;
      ff  = '0;
      fs  = 1'b0;
      pos = '0;
      ov  = 1'b0;
    end

    string_open_next        = so;
    escape_pending_next     = ep;
    paren_depth_next        = pd;
    brace_depth_next        = bd;
    bracket_depth_next      = kd;
    dollar_pending_next     = dp;
    word_open_next          = wo;
    current_word_start_next = cws;
    word_total_next         = wt;
    first_word_begin_next   = fb;
    first_word_finish_next  = ff;
    first_word_seen_next    = fs;
    char_position_next      = pos;
    overflow_seen_next      = ov;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      string_open        <= 1'b0;
      escape_pending     <= 1'b0;
      paren_depth        <= '0;
      brace_depth        <= '0;
      bracket_depth      <= '0;
      dollar_pending     <= 1'b0;
      word_open          <= 1'b0;
      current_word_start <= '0;
      word_total         <= '0;
      first_word_begin   <= '0;
      first_word_finish  <= '0;
      first_word_seen    <= 1'b0;
      char_position      <= '0;
      overflow_seen      <= 1'b0;
    end else if (take) begin
      string_open        <= string_open_next;
      escape_pending     <= escape_pending_next;
      paren_depth        <= paren_depth_next;
      brace_depth        <= brace_depth_next;
      bracket_depth      <= bracket_depth_next;
      dollar_pending     <= dollar_pending_next;
      word_open          <= word_open_next;
      current_word_start <= current_word_start_next;
      word_total         <= word_total_next;
      first_word_begin   <= first_word_begin_next;
      first_word_finish  <= first_word_finish_next;
      first_word_seen    <= first_word_seen_next;
      char_position      <= char_position_next;
      overflow_seen      <= overflow_seen_next;
    end
  end

endmodule

// ===== rtl/core/slcs_checker.sv =====
// Port-level checks for the shell line context scanner, bound to its top level.
// Depends on slcs_pkg and shell_line_context_scanner.
`timescale 1ns / 1ps

module slcs_checker import slcs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_cursor_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cursor_here |=> out_valid)
    else $error("cursor beat gave no result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result is stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_first_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.first_valid |->
      out_data.first_start_pos == '0 && out_data.first_end_pos == '0)
    else $error("first word span set without a first word");

endmodule

bind shell_line_context_scanner slcs_checker u_slcs_checker (.*);

// ===== bench/shell_line_context_scanner_tb.sv =====
// Self-checking bench for the shell line context scanner: a directed table, then random
// command lines under several idle and stall mixes, scored against a local line model
// or a typed row's own report. Depends on slcs_pkg and the shell_line_context_scanner RTL.
`timescale 1ns / 1ps

module shell_line_context_scanner_tb;
  import slcs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned PHASES         = 4;

  typedef struct {
    logic [7:0] ch_a;
    logic [7:0] ch_b;
    bit         two;
    bit         no_char;
    bit         cursor;
    int unsigned reps;
    bit         typed;
    out_beat_t  want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  out_beat_t   line_reports[$];
  script_row_t script[$];
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // line model state
  logic       str_open;
  logic       escaped;
  logic [3:0] paren_lvl;
  logic [3:0] brace_lvl;
  logic [3:0] bracket_lvl;
  logic       dollar_seen;
  logic       in_word;
  logic [9:0] word_begin;
  logic [9:0] words_done;
  logic [9:0] head_begin;
  logic [9:0] head_end;
  logic       head_seen;
  logic [9:0] col;
  logic       overflowed;

  shell_line_context_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_scan();
    str_open    = 1'b0;
    escaped     = 1'b0;
    paren_lvl   = '0;
    brace_lvl   = '0;
    bracket_lvl = '0;
    dollar_seen = 1'b0;
    in_word     = 1'b0;
    word_begin  = '0;
    words_done  = '0;
    head_begin  = '0;
    head_end    = '0;
    head_seen   = 1'b0;
    col         = '0;
    overflowed  = 1'b0;
  endfunction

  function automatic logic [3:0] raised(input logic [3:0] lvl);
    if (lvl >= MAX_DEPTH_DEF) begin
      overflowed = 1'b1;
      return 4'(MAX_DEPTH_DEF);
    end
    return lvl + 4'd1;
  endfunction

  function automatic logic nested_open();
    return str_open || paren_lvl != 0 || brace_lvl != 0 || bracket_lvl != 0;
  endfunction

  function automatic void step_col();
    if (col < LINE_LIMIT_DEF) col = col + 10'd1;
    else overflowed = 1'b1;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic [9:0] at;
    at = col;
    if (dollar_seen) begin
      dollar_seen = 1'b0;
      if (c == CH_LBRACE) begin
        brace_lvl = raised(brace_lvl);
        step_col();
        return;
      end
      if (c == CH_LPAREN && !str_open) begin
        paren_lvl = raised(paren_lvl);
        step_col();
        return;
      end
    end
    if (!nested_open()) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        if (in_word) begin
          if (!head_seen) begin
            head_seen  = 1'b1;
            head_begin = word_begin;
            head_end   = at;
          end
          if (words_done < WORD_SAT) words_done = words_done + 10'd1;
          in_word = 1'b0;
        end
      end else if (!in_word) begin
        in_word    = 1'b1;
        word_begin = at;
      end
    end
    if (str_open) begin
      if (escaped) escaped = 1'b0;
      else if (c == CH_BACKSLASH) escaped = 1'b1;
      else if (c == CH_DOLLAR) dollar_seen = 1'b1;
      else if (c == CH_QUOTE) str_open = 1'b0;
    end else if (brace_lvl != 0) begin
      if (c == CH_QUOTE) str_open = 1'b1;
      else if (c == CH_RBRACE) brace_lvl = brace_lvl - 4'd1;
      else if (c == CH_DOLLAR) dollar_seen = 1'b1;
      else if (c == CH_LPAREN) paren_lvl = raised(paren_lvl);
      else if (c == CH_RPAREN && paren_lvl != 0) paren_lvl = paren_lvl - 4'd1;
    end else if (paren_lvl != 0) begin
      if (c == CH_QUOTE) str_open = 1'b1;
      else if (c == CH_DOLLAR) dollar_seen = 1'b1;
      else if (c == CH_LPAREN) paren_lvl = raised(paren_lvl);
      else if (c == CH_RPAREN) paren_lvl = paren_lvl - 4'd1;
    end else begin
      if (c == CH_QUOTE) str_open = 1'b1;
      else if (c == CH_DOLLAR) dollar_seen = 1'b1;
      else if (c == CH_LBRACKET) bracket_lvl = raised(bracket_lvl);
      else if (c == CH_RBRACKET && bracket_lvl != 0) bracket_lvl = bracket_lvl - 4'd1;
    end
    step_col();
  endfunction

  function automatic out_beat_t close_line();
    out_beat_t r;
    r.word_start_pos  = in_word ? word_begin : col;
    r.words_before    = words_done;
    r.in_special      = nested_open();
    r.first_valid     = head_seen;
    r.first_start_pos = head_seen ? head_begin : '0;
    r.first_end_pos   = head_seen ? head_end : '0;
    r.depth_overflow  = overflowed;
    reset_scan();
    return r;
  endfunction

  function automatic out_beat_t make_report(input int unsigned ws, input int unsigned wb,
                                            input bit sp, input bit fv, input int unsigned fs,
                                            input int unsigned fe, input bit ov);
    out_beat_t r;
    r.word_start_pos  = 10'(ws);
    r.words_before    = 10'(wb);
    r.in_special      = sp;
    r.first_valid     = fv;
    r.first_start_pos = 10'(fs);
    r.first_end_pos   = 10'(fe);
    r.depth_overflow  = ov;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] a, input logic [7:0] b, input bit two,
                                  input bit nc, input bit cur, input int unsigned reps,
                                  input bit typed = 1'b0, input out_beat_t want = '0);
    script_row_t row;
    row.ch_a    = a;
    row.ch_b    = b;
    row.two     = two;
    row.no_char = nc;
    row.cursor  = cur;
    row.reps    = reps;
    row.typed   = typed;
    row.want    = want;
    script.push_back(row);
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (!b.no_char) scan_char(b.char_code);
    if (b.cursor_here) begin
      r = close_line();
      line_reports.push_back(typed ? want : r);
    end
  endtask

  task automatic drain_reports();
    while (line_reports.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] specials[9];
    int unsigned r;
    specials = '{CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                 CH_LBRACKET, CH_RBRACKET, CH_QUOTE, CH_BACKSLASH};
    r = $urandom_range(99);
    if (r < 30) return 8'h61 + 8'($urandom_range(25));
    if (r < 38) return CH_SPACE;
    if (r < 45) return CH_TAB + 8'($urandom_range(4));
    if (r < 80) return specials[$urandom_range(8)];
    return 8'($urandom_range(255));
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : score_reports
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (line_reports.size() == 0) begin
        $display("%0t: unexpected report expected none got %p", $time, out_data);
        errors++;
      end else begin
        want = line_reports.pop_front();
        check_field("word_start_pos", want.word_start_pos, out_data.word_start_pos);
        check_field("words_before", want.words_before, out_data.words_before);
        check_field("in_special", want.in_special, out_data.in_special);
        check_field("first_valid", want.first_valid, out_data.first_valid);
        check_field("first_start_pos", want.first_start_pos, out_data.first_start_pos);
        check_field("first_end_pos", want.first_end_pos, out_data.first_end_pos);
        check_field("depth_overflow", want.depth_overflow, out_data.depth_overflow);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("shell_line_context_scanner_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_beat_t    b;
    script_row_t row;
    int unsigned idle_mix[PHASES];
    int unsigned stall_mix[PHASES];
    int unsigned items;
    int unsigned len;
    bit          last;

    idle_mix       = '{0, 69, 0, 35};
    stall_mix      = '{0, 0, 69, 35};
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    errors         = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items          = 0;
    reset_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_row(8'h00, 8'h00, 0, 1, 1, 1, 1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(8'hFF, 8'h00, 0, 1, 0, 1);
    add_row(8'h00, 8'h00, 0, 0, 1, 1, 1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(8'hFF, CH_TAB, 1, 0, 0, 1);
    add_row(CH_CR, 8'h00, 0, 0, 1, 1, 1, make_report(3, 1, 0, 1, 0, 1, 0));
    add_row(8'h08, 8'h0E, 1, 0, 1, 1);
    add_row(CH_DOLLAR, 8'h00, 0, 0, 1, 1, 1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(CH_DOLLAR, CH_LBRACE, 1, 0, 0, 1);
    add_row("x", 8'h00, 0, 0, 1, 1);
    add_row(CH_DOLLAR, CH_LPAREN, 1, 0, 0, 1);
    add_row(CH_LPAREN, CH_RPAREN, 1, 0, 1, 1);
    add_row(CH_QUOTE, CH_DOLLAR, 1, 0, 0, 1);
    add_row(CH_LPAREN, CH_DOLLAR, 1, 0, 0, 1);
    add_row(CH_LBRACE, CH_BACKSLASH, 1, 0, 0, 1);
    add_row(CH_QUOTE, 8'h00, 0, 0, 1, 1);
    add_row(CH_DOLLAR, CH_LBRACE, 1, 0, 0, 1);
    add_row(CH_RPAREN, CH_RBRACKET, 1, 0, 0, 1);
    add_row(CH_RBRACE, CH_SPACE, 1, 0, 0, 1);
    add_row(CH_DOLLAR, "a", 1, 0, 1, 1);
    add_row(CH_LBRACKET, 8'h00, 0, 0, 1, 16, 1, make_report(0, 0, 1, 0, 0, 0, 1));
    add_row(CH_DOLLAR, CH_LPAREN, 1, 0, 0, 1);
    add_row(CH_LPAREN, 8'h00, 0, 0, 1, 15);
    add_row(CH_DOLLAR, CH_LBRACE, 1, 0, 1, 16);
    add_row(CH_SPACE, 8'h00, 0, 0, 1, 1030, 1, make_report(1023, 0, 0, 0, 0, 0, 1));
    add_row("w", CH_SPACE, 1, 0, 0, 1100);
    add_row(8'h00, 8'h00, 0, 1, 1, 1, 1, make_report(1023, 1023, 0, 1, 0, 1, 1));

    foreach (script[i]) begin
      row = script[i];
      for (int unsigned r = 0; r < row.reps; r++) begin
        last = (r == row.reps - 1);
        b = '{row.ch_a, row.no_char, row.cursor && last && !row.two};
        send_beat(b, row.typed, row.want);
        if (row.two) begin
          b = '{row.ch_b, 1'b0, row.cursor && last};
          send_beat(b, row.typed, row.want);
        end
      end
    end
    drain_reports();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      send_idle_pct  <= idle_mix[phase];
      recv_stall_pct <= stall_mix[phase];
      while (items < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        len = ($urandom_range(99) == 0) ? $urandom_range(1100, 1000) : $urandom_range(24);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(49) == 0) begin
            b = '{8'($urandom_range(255)), 1'b1, 1'b0};
            send_beat(b, 1'b0, '0);
          end
          b = '{pick_char(), 1'b0, 1'b0};
          send_beat(b, 1'b0, '0);
        end
        b = '{pick_char(), 1'($urandom_range(1)), 1'b1};
        send_beat(b, 1'b0, '0);
        items += len + 1;
      end
      drain_reports();
    end

    in_valid <= 1'b0;
    while (line_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("shell_line_context_scanner_tb: PASS");
    end else begin
      $display("shell_line_context_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/slcs_pkg.sv
rtl/core/slcs_track.sv
rtl/core/shell_line_context_scanner.sv
rtl/core/slcs_checker.sv
bench/shell_line_context_scanner_tb.sv
